>>> rtl/core/kprp_pkg.sv
// Shared types and constants for the key pattern recorder and player.
package kprp_pkg;

  localparam int unsigned SongDepth = 1024;
  localparam int unsigned AddrW     = (SongDepth > 1) ? $clog2(SongDepth) : 1;
  localparam int unsigned LenW      = $clog2(SongDepth + 1);
  localparam int unsigned NumKeys   = 5;
  localparam int unsigned LevelW    = 8;
  localparam int unsigned RegW      = 8;

  localparam logic [RegW-1:0] ThresholdReset = 8'd50;
  localparam logic [RegW-1:0] DivideReset    = 8'd2;

  typedef enum logic [1:0] {
    OpTick   = 2'd0,
    OpPlay   = 2'd1,
    OpRecord = 2'd2,
    OpStop   = 2'd3
  } op_e;

  typedef enum logic {
    CfgThreshold = 1'b0,
    CfgDivide    = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ModeIdle = 3'b001,
    ModePlay = 3'b010,
    ModeRec  = 3'b100
  } mode_e;

  typedef struct packed {
    logic               use_mem;
    logic               use_live;
    logic [NumKeys-1:0] live;
    logic               play;
    logic               rec;
  } stage_t;

endpackage

>>> rtl/core/kprp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kprp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/key_pattern_record_playback.sv
// Top level of the five-key pattern recorder and looping player.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------
//  in      | input     | in_valid_i / in_ready_o | op_i, key1_level_i .. key5_level_i
//  out     | output    | out_valid_o/out_ready_i | key_drive_o, play_lamp_o, record_lamp_o
//  cfg     | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// One transaction per cycle in and out while the output is not stalled; on acceptance
// the control state is updated and the song memory is read into its read register,
// and the result register is loaded from the staged item once the output can move.
// Reset puts the mode to idle and clears the length, position, tick count and drive.
// A stalled output holds the result register and the staged item; input is
// taken whenever the stage is empty or the staged item can move on in the same cycle.
module key_pattern_record_playback (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      op_i,
  input  logic [kprp_pkg::LevelW-1:0]     key1_level_i,
  input  logic [kprp_pkg::LevelW-1:0]     key2_level_i,
  input  logic [kprp_pkg::LevelW-1:0]     key3_level_i,
  input  logic [kprp_pkg::LevelW-1:0]     key4_level_i,
  input  logic [kprp_pkg::LevelW-1:0]     key5_level_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [kprp_pkg::NumKeys-1:0]    key_drive_o,
  output logic                            play_lamp_o,
  output logic                            record_lamp_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [kprp_pkg::RegW-1:0]       cfg_data_i
);

  logic [kprp_pkg::RegW-1:0]    thresh_q;
  logic [kprp_pkg::RegW-1:0]    divide_q;
  kprp_pkg::mode_e              mode_q, mode_d;
  logic [kprp_pkg::LenW-1:0]    len_q, len_d;
  logic [kprp_pkg::LenW-1:0]    pos_q, pos_d;
  logic [kprp_pkg::RegW-1:0]    tick_q, tick_d, tick_inc;
  logic                         s1_valid_q;
  kprp_pkg::stage_t             s1_q, s1_d;
  logic                         out_valid_q;
  logic [kprp_pkg::NumKeys-1:0] drive_q, drive_d;
  logic                         play_q, rec_q;
  logic                         accept, s1_move, step;
  logic [kprp_pkg::NumKeys-1:0] live;
  logic                         ram_we, ram_re;
  logic [kprp_pkg::NumKeys-1:0] ram_rdata;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign accept     = in_valid_i && in_ready_o;

  assign live[0] = key1_level_i >= thresh_q;
  assign live[1] = key2_level_i >= thresh_q;
  assign live[2] = key3_level_i >= thresh_q;
  assign live[3] = key4_level_i >= thresh_q;
  assign live[4] = key5_level_i >= thresh_q;

  assign tick_inc = tick_q + 1'b1;
  assign step     = tick_inc >= divide_q;

  always_comb begin
    mode_d  = mode_q;
    len_d   = len_q;
    pos_d   = pos_q;
    tick_d  = tick_q;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    s1_d    = '0;
    case (kprp_pkg::op_e'(op_i))
      kprp_pkg::OpTick: begin
        if (mode_q != kprp_pkg::ModeIdle) begin
          tick_d = step ? '0 : tick_inc;
          if (step && mode_q == kprp_pkg::ModeRec) begin
            if (len_q >= kprp_pkg::LenW'(kprp_pkg::SongDepth)) begin
              mode_d = kprp_pkg::ModeIdle;
            end else begin
              ram_we = 1'b1;
              len_d  = len_q + 1'b1;
            end
          end else if (step && mode_q == kprp_pkg::ModePlay) begin
            if (len_q == '0) begin
              mode_d = kprp_pkg::ModeIdle;
            end else if (pos_q >= len_q) begin
              pos_d = '0;
            end else begin
              ram_re = 1'b1;
              pos_d  = pos_q + 1'b1;
            end
          end
        end
      end
      kprp_pkg::OpPlay: begin
        if (mode_q == kprp_pkg::ModePlay) begin
          mode_d = kprp_pkg::ModeIdle;
        end else if (mode_q != kprp_pkg::ModeRec) begin
          mode_d = kprp_pkg::ModePlay;
          pos_d  = '0;
        end
      end
      kprp_pkg::OpRecord: begin
        if (mode_q == kprp_pkg::ModeRec) begin
          mode_d = kprp_pkg::ModeIdle;
        end else if (mode_q != kprp_pkg::ModePlay) begin
          mode_d = kprp_pkg::ModeRec;
          len_d  = '0;
        end
      end
      default: begin
        mode_d = kprp_pkg::ModeIdle;
      end
    endcase
    s1_d.use_mem  = ram_re;
    s1_d.use_live = mode_d != kprp_pkg::ModePlay;
    s1_d.live     = live;
    s1_d.play     = mode_d == kprp_pkg::ModePlay;
    s1_d.rec      = mode_d == kprp_pkg::ModeRec;
  end

  always_comb begin
    drive_d = drive_q;
    if (s1_q.use_live) begin
      drive_d = s1_q.live;
    end else if (s1_q.use_mem) begin
      drive_d = ram_rdata;
    end
  end

  kprp_ram #(
    .Width(kprp_pkg::NumKeys),
    .Depth(kprp_pkg::SongDepth)
  ) u_song_ram (
    .clk_i  (clk_i),
    .we_i   (accept && ram_we),
    .waddr_i(len_q[kprp_pkg::AddrW-1:0]),
    .wdata_i(live),
    .re_i   (accept && ram_re),
    .raddr_i(pos_q[kprp_pkg::AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= kprp_pkg::ThresholdReset;
      divide_q <= kprp_pkg::DivideReset;
    end else if (cfg_we_i) begin
      case (kprp_pkg::cfg_idx_e'(cfg_idx_i))
        kprp_pkg::CfgThreshold: thresh_q <= cfg_data_i;
        kprp_pkg::CfgDivide:    divide_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= kprp_pkg::ModeIdle;
      len_q      <= '0;
      pos_q      <= '0;
      tick_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mode_q <= mode_d;
        len_q  <= len_d;
        pos_q  <= pos_d;
        tick_q <= tick_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      drive_q     <= '0;
      play_q      <= 1'b0;
      rec_q       <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        drive_q <= drive_d;
        play_q  <= s1_q.play;
        rec_q   <= s1_q.rec;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign key_drive_o   = drive_q;
  assign play_lamp_o   = play_q;
  assign record_lamp_o = rec_q;

`ifndef ASSERT_OFF
  a_lamps_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(play_q && rec_q))
    else $error("play and record lamps both lit");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= kprp_pkg::LenW'(kprp_pkg::SongDepth))
    else $error("stored length beyond song depth");

  a_pos_in_song: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == kprp_pkg::ModePlay) |-> (pos_q <= len_q))
    else $error("play position beyond stored length");

  a_ram_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("song memory read and written by one transaction");

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |=> (s1_valid_q && $stable(s1_q)))
    else $error("staged transaction lost during stall");
`endif

endmodule
